// ===== hw/rtl/mvp_pkg.sv =====
// Shared constants, types and helpers for the multichannel velocity PID.
package mvp_pkg;

	localparam int CHANNELS   = 8;
	localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CH_W       = 3;
	localparam int DATA_W     = 32;
	localparam int REG_IDX_W  = 3;

	// Q37.32 sum of the three products, and that sum floored to Q37.16
	localparam int SUM_W      = 69;
	localparam int FRAC_W     = 16;
	localparam int SHIFT_W    = SUM_W - FRAC_W;
	localparam int EXT_W      = SHIFT_W + 1;

	// Items in flight: four pipeline stages plus the result register
	localparam int PIPE_DEPTH = 5;

	localparam logic signed [DATA_W-1:0] OUT_MIN_RST = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] OUT_MAX_RST = {1'b0, {(DATA_W-1){1'b1}}};

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PROP_GAIN     = 3'd0,
		REG_INTEG_GAIN_DT = 3'd1,
		REG_DERIV_GAIN_DT = 3'd2,
		REG_OUT_MIN       = 3'd3,
		REG_OUT_MAX       = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] prop_gain;
		logic signed [DATA_W-1:0] integ_gain_dt;
		logic signed [DATA_W-1:0] deriv_gain_dt;
		logic signed [DATA_W-1:0] out_min;
		logic signed [DATA_W-1:0] out_max;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0]           channel;
		logic                      in_range;
		logic signed [SHIFT_W-1:0] sh_base;
		logic signed [SHIFT_W-1:0] sh_full;
	} sum_beat_t;

	function automatic logic ch_valid(input logic [CH_W-1:0] ch);
		return int'(ch) < CHANNELS;
	endfunction

	function automatic logic [CH_IDX_W-1:0] ch_idx(input logic [CH_W-1:0] ch);
		return CH_IDX_W'(ch);
	endfunction

endpackage

// ===== hw/rtl/mvp_if.sv =====
// Handshake channels: error samples in, drive values out, register writes.
interface mvp_sample_if;
	import mvp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CH_W-1:0]          channel;
	logic signed [DATA_W-1:0] error_sample;
	modport source (output valid, channel, error_sample, input ready);
	modport sink   (input valid, channel, error_sample, output ready);
endinterface

interface mvp_result_if;
	import mvp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CH_W-1:0]          out_channel;
	logic signed [DATA_W-1:0] drive;
	modport source (output valid, out_channel, drive, input ready);
	modport sink   (input valid, out_channel, drive, output ready);
endinterface

interface mvp_cfg_if;
	import mvp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mvp_cfg_regs.sv =====
// Gain and limit registers written through the configuration channel.
module mvp_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	mvp_cfg_if.sink      cfg,
	output mvp_pkg::cfg_t cfg_regs
);
	import mvp_pkg::*;

	cfg_t cfg_q;

	assign cfg.ready = 1'b1;
	assign cfg_regs  = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= '0;
			cfg_q.integ_gain_dt <= '0;
			cfg_q.deriv_gain_dt <= '0;
			cfg_q.out_min       <= OUT_MIN_RST;
			cfg_q.out_max       <= OUT_MAX_RST;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_PROP_GAIN:     cfg_q.prop_gain     <= cfg.data;
				REG_INTEG_GAIN_DT: cfg_q.integ_gain_dt <= cfg.data;
				REG_DERIV_GAIN_DT: cfg_q.deriv_gain_dt <= cfg.data;
				REG_OUT_MIN:       cfg_q.out_min       <= cfg.data;
				REG_OUT_MAX:       cfg_q.out_max       <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/mvp_err_hist.sv =====
// Per-channel history of the last two error samples.
module mvp_err_hist (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [mvp_pkg::CH_W-1:0]         channel,
	input  logic signed [mvp_pkg::DATA_W-1:0] error_sample,
	output logic signed [mvp_pkg::DATA_W-1:0] last_error,
	output logic signed [mvp_pkg::DATA_W-1:0] prior_error
);
	import mvp_pkg::*;

	logic signed [DATA_W-1:0] last_error_q  [CHANNELS];
	logic signed [DATA_W-1:0] prior_error_q [CHANNELS];
	logic [CH_IDX_W-1:0]      idx;
	logic                     hit;

	assign idx = ch_idx(channel);
	assign hit = ch_valid(channel);

	assign last_error  = hit ? last_error_q[idx]  : '0;
	assign prior_error = hit ? prior_error_q[idx] : '0;

	// Errors shift in at accept; nothing downstream feeds back into them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				last_error_q[i]  <= '0;
				prior_error_q[i] <= '0;
			end
		end else if (wr_en && hit) begin
			prior_error_q[idx] <= last_error_q[idx];
			last_error_q[idx]  <= error_sample;
		end
	end

endmodule

// ===== hw/rtl/mvp_pipe.sv =====
// Error differences, gain products and their Q37.32 sums, four stages.
module mvp_pipe (
	input  logic                              clk,
	input  logic                              arst_n,
	mvp_sample_if.sink                        sample,
	input  logic signed [mvp_pkg::DATA_W-1:0] last_error,
	input  logic signed [mvp_pkg::DATA_W-1:0] prior_error,
	input  mvp_pkg::cfg_t                     cfg_regs,
	output mvp_pkg::sum_beat_t                beat,
	output logic                              beat_valid,
	input  logic                              beat_ready
);
	import mvp_pkg::*;

	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [CH_W-1:0]          ch_s1, ch_s2, ch_s3, ch_s4;
	logic                     inr_s1, inr_s2, inr_s3, inr_s4;
	logic signed [DATA_W-1:0] e_s1, e1_s1, e2_s1, e_s2;
	logic signed [DATA_W:0]   d1_s2;
	logic signed [DATA_W+2:0] d2_s2;
	logic signed [2*DATA_W:0]   p_kp_s3;
	logic signed [2*DATA_W-1:0] p_ki_s3;
	logic signed [2*DATA_W+2:0] p_kd_s3;
	logic signed [SHIFT_W-1:0]  sh_base_s4, sh_full_s4;

	logic signed [SUM_W-1:0] sum_base, sum_full;

	// A stage loads when it is empty or its content moves on
	assign en4 = !v_s4 || beat_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign sample.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= sample.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	assign sum_base = SUM_W'(p_kp_s3) + SUM_W'(p_kd_s3);
	assign sum_full = sum_base + SUM_W'(p_ki_s3);

	always_ff @(posedge clk) begin
		if (en1) begin
			ch_s1  <= sample.channel;
			inr_s1 <= ch_valid(sample.channel);
			e_s1   <= sample.error_sample;
			e1_s1  <= last_error;
			e2_s1  <= prior_error;
		end
		if (en2) begin
			ch_s2  <= ch_s1;
			inr_s2 <= inr_s1;
			e_s2   <= e_s1;
			d1_s2  <= (DATA_W+1)'(e_s1) - (DATA_W+1)'(e1_s1);
			d2_s2  <= (DATA_W+3)'(e_s1) - ((DATA_W+3)'(e1_s1) <<< 1) + (DATA_W+3)'(e2_s1);
		end
		if (en3) begin
			ch_s3   <= ch_s2;
			inr_s3  <= inr_s2;
			p_kp_s3 <= (2*DATA_W+1)'($signed(cfg_regs.prop_gain)) * (2*DATA_W+1)'(d1_s2);
			p_ki_s3 <= (2*DATA_W)'($signed(cfg_regs.integ_gain_dt)) * (2*DATA_W)'(e_s2);
			p_kd_s3 <= (2*DATA_W+3)'($signed(cfg_regs.deriv_gain_dt)) * (2*DATA_W+3)'(d2_s2);
		end
		if (en4) begin
			ch_s4      <= ch_s3;
			inr_s4     <= inr_s3;
			// floor to Q37.16: drop the low fraction bits of the two's complement sum
			sh_base_s4 <= sum_base[SUM_W-1:FRAC_W];
			sh_full_s4 <= sum_full[SUM_W-1:FRAC_W];
		end
	end

	assign beat_valid     = v_s4;
	assign beat.channel   = ch_s4;
	assign beat.in_range  = inr_s4;
	assign beat.sh_base   = sh_base_s4;
	assign beat.sh_full   = sh_full_s4;

endmodule

// ===== hw/rtl/mvp_out_stage.sv =====
// Anti-windup select, accumulate onto the last output, clamp, result register.
module mvp_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  mvp_pkg::cfg_t      cfg_regs,
	input  mvp_pkg::sum_beat_t beat,
	input  logic               beat_valid,
	output logic               beat_ready,
	mvp_result_if.source       result
);
	import mvp_pkg::*;

	logic signed [DATA_W-1:0] last_output_q [CHANNELS];
	logic                     out_v_q;
	logic [CH_W-1:0]          out_ch_q;
	logic signed [DATA_W-1:0] drive_q;

	logic [CH_IDX_W-1:0]       idx;
	logic signed [DATA_W-1:0]  y;
	logic                      windup;
	logic signed [SHIFT_W-1:0] sh;
	logic signed [EXT_W-1:0]   z, min_w, max_w;
	logic signed [DATA_W-1:0]  clamped;
	logic                      take;

	assign idx = ch_idx(beat.channel);
	assign y   = beat.in_range ? last_output_q[idx] : '0;

	// Drop the integral term while the old output sits on or beyond a limit
	assign windup = (y <= cfg_regs.out_min) || (y >= cfg_regs.out_max);
	assign sh     = windup ? beat.sh_base : beat.sh_full;

	assign z     = EXT_W'(y) + EXT_W'(sh);
	assign min_w = EXT_W'($signed(cfg_regs.out_min));
	assign max_w = EXT_W'($signed(cfg_regs.out_max));

	always_comb begin
		if (z < min_w) begin
			clamped = cfg_regs.out_min;
		end else if (z > max_w) begin
			clamped = cfg_regs.out_max;
		end else begin
			clamped = z[DATA_W-1:0];
		end
	end

	assign beat_ready = !out_v_q || result.ready;
	assign take       = beat_valid && beat_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				last_output_q[i] <= '0;
			end
		end else begin
			if (beat_ready) out_v_q <= beat_valid;
			if (take && beat.in_range) last_output_q[idx] <= clamped;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_ch_q <= beat.channel;
			drive_q  <= beat.in_range ? clamped : '0;
		end
	end

	assign result.valid       = out_v_q;
	assign result.out_channel = out_ch_q;
	assign result.drive       = drive_q;

endmodule

// ===== hw/rtl/multichannel_velocity_pid.sv =====
// Velocity-form PID serving eight control loops, Q16.16 on its data ports.
// Each error sample beat names a loop; the block returns one drive beat for it, in order,
// computed as the loop's previous drive plus kp*(e-e1) + ki_dt*e + kd_dt*(e-2*e1+e2),
// floored to Q16.16 and clamped to [out_min, out_max]; the ki_dt term is skipped while the
// previous drive sits at or beyond a limit. A sample is taken every cycle unless the
// output stalls; a drive passes the input register, the difference stage, the multiplier
// stage (three gain products in parallel), the summing stage and the clamp stage into the
// result register. Samples for one loop may follow each other back to back: a loop's
// previous drive is written as its result leaves the clamp stage, before the next sample
// reaches it. Registers must be written only while idle; the block does not enforce it.
module multichannel_velocity_pid (
	input  logic          clk,
	input  logic          arst_n,
	mvp_cfg_if.sink       cfg,
	mvp_sample_if.sink    sample,
	mvp_result_if.source  result
);
	import mvp_pkg::*;

	cfg_t                     cfg_regs;
	sum_beat_t                beat;
	logic                     beat_valid;
	logic                     beat_ready;
	logic                     smp_acc;
	logic signed [DATA_W-1:0] last_error;
	logic signed [DATA_W-1:0] prior_error;

	assign smp_acc = sample.valid && sample.ready;

	mvp_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_regs (cfg_regs)
	);

	mvp_err_hist u_err_hist (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (smp_acc),
		.channel      (sample.channel),
		.error_sample (sample.error_sample),
		.last_error   (last_error),
		.prior_error  (prior_error)
	);

	mvp_pipe u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample),
		.last_error  (last_error),
		.prior_error (prior_error),
		.cfg_regs    (cfg_regs),
		.beat        (beat),
		.beat_valid  (beat_valid),
		.beat_ready  (beat_ready)
	);

	mvp_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_regs   (cfg_regs),
		.beat       (beat),
		.beat_valid (beat_valid),
		.beat_ready (beat_ready),
		.result     (result)
	);

endmodule

// ===== hw/rtl/mvp_checker.sv =====
// Port-level checks for the multichannel velocity PID, bound to the top level.
module mvp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_valid,
	input logic                          sample_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [mvp_pkg::CH_W-1:0]      result_out_channel,
	input logic signed [mvp_pkg::DATA_W-1:0] result_drive,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [mvp_pkg::REG_IDX_W-1:0] cfg_index,
	input logic [mvp_pkg::DATA_W-1:0]    cfg_data
);
	import mvp_pkg::*;

	logic [2:0]               cnt_q;
	logic signed [DATA_W-1:0] min_q;
	logic signed [DATA_W-1:0] max_q;
	logic                     in_beat;
	logic                     out_beat;

	assign in_beat  = sample_valid && sample_ready;
	assign out_beat = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			min_q <= OUT_MIN_RST;
			max_q <= OUT_MAX_RST;
		end else begin
			if (in_beat && !out_beat) cnt_q <= cnt_q + 3'd1;
			if (!in_beat && out_beat) cnt_q <= cnt_q - 3'd1;
			if (cfg_valid && cfg_ready) begin
				unique case (reg_idx_t'(cfg_index))
					REG_OUT_MIN: min_q <= cfg_data;
					REG_OUT_MAX: max_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(result_drive) && $stable(result_out_channel))
		else $error("result beat changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> cnt_q != 3'd0)
		else $error("result beat without an outstanding sample");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(PIPE_DEPTH))
		else $error("more samples in flight than pipeline slots");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (min_q <= max_q) && (int'(result_out_channel) < CHANNELS) |->
			(result_drive >= min_q) && (result_drive <= max_q))
		else $error("drive outside the configured limits");

endmodule

bind multichannel_velocity_pid mvp_checker u_mvp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.sample_valid       (sample.valid),
	.sample_ready       (sample.ready),
	.result_valid       (result.valid),
	.result_ready       (result.ready),
	.result_out_channel (result.out_channel),
	.result_drive       (result.drive),
	.cfg_valid          (cfg.valid),
	.cfg_ready          (cfg.ready),
	.cfg_index          (cfg.index),
	.cfg_data           (cfg.data)
);

// ===== tb/sv/tb_multichannel_velocity_pid.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the multichannel velocity PID: directed table, then random samples.
module tb_multichannel_velocity_pid;
	import mvp_pkg::*;

	localparam int SEG_ITEMS   = 200;
	localparam int SEGMENTS    = 6;
	localparam int STALL_LIMIT = 4000;
	localparam int PLAN_ROWS   = 28;

	localparam logic signed [DATA_W-1:0] Q_MIN     = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] LIM_100_N = 32'shFF9C_0000;
	localparam logic signed [DATA_W-1:0] LIM_100_P = 32'sh0064_0000;

	typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		reg_idx_t          idx;
		logic [CH_W-1:0]   ch;
		logic [DATA_W-1:0] value;
		logic              typed;
		logic [DATA_W-1:0] want;
	} plan_row_t;

	typedef struct packed {
		logic [CH_W-1:0]          ch;
		logic signed [DATA_W-1:0] drive;
	} drive_beat_t;

	logic clk;
	logic arst_n;

	mvp_cfg_if    cfg_bus();
	mvp_sample_if smp_bus();
	mvp_result_if res_bus();

	multichannel_velocity_pid dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.sample (smp_bus),
		.result (res_bus)
	);

	// Predictor copy of gains, limits and per-loop history
	logic signed [DATA_W-1:0] kp_now, ki_now, kd_now, lim_lo, lim_hi;
	logic signed [DATA_W-1:0] loop_drive [CHANNELS];
	logic signed [DATA_W-1:0] loop_err1  [CHANNELS];
	logic signed [DATA_W-1:0] loop_err2  [CHANNELS];

	drive_beat_t     pending_drives [$];
	int unsigned     mismatches;
	int unsigned     src_idle_pct;
	int unsigned     snk_idle_pct;
	int unsigned     stall_cycles;
	logic [CH_W-1:0] last_ch;

	// Typed expectations: zero gains give zero drive, full-scale gains saturate
	plan_row_t plan [PLAN_ROWS] = '{
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd0, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000},
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd7, 32'h8000_0000, 1'b1, 32'h0000_0000},
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd3, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd0, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{ROW_CFG,    REG_PROP_GAIN,     3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
		'{ROW_CFG,    REG_INTEG_GAIN_DT, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
		'{ROW_CFG,    REG_DERIV_GAIN_DT, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd1, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd2, 32'h8000_0000, 1'b1, 32'h8000_0000},
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd1, 32'h0000_0000, 1'b1, 32'h8000_0000},
		'{ROW_CFG,    REG_PROP_GAIN,     3'd0, 32'h8000_0000, 1'b0, 32'h0000_0000},
		'{ROW_CFG,    REG_DERIV_GAIN_DT, 3'd0, 32'h8000_0000, 1'b0, 32'h0000_0000},
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd5, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
		'{ROW_CFG,    REG_OUT_MIN,       3'd0, 32'h0001_0000, 1'b0, 32'h0000_0000},
		'{ROW_CFG,    REG_OUT_MAX,       3'd0, 32'hFFFF_0000, 1'b0, 32'h0000_0000},
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd4, 32'h0005_0000, 1'b0, 32'h0000_0000},
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd4, 32'hFFFB_0000, 1'b0, 32'h0000_0000},
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd6, 32'h8000_0000, 1'b0, 32'h0000_0000},
		'{ROW_CFG,    REG_OUT_MIN,       3'd0, 32'hFF9C_0000, 1'b0, 32'h0000_0000},
		'{ROW_CFG,    REG_OUT_MAX,       3'd0, 32'h0064_0000, 1'b0, 32'h0000_0000},
		'{ROW_CFG,    REG_PROP_GAIN,     3'd0, 32'h0001_0000, 1'b0, 32'h0000_0000},
		'{ROW_CFG,    REG_INTEG_GAIN_DT, 3'd0, 32'h0000_8000, 1'b0, 32'h0000_0000},
		'{ROW_CFG,    REG_DERIV_GAIN_DT, 3'd0, 32'h0000_4000, 1'b0, 32'h0000_0000},
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd4, 32'h0003_0000, 1'b0, 32'h0000_0000},
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd4, 32'h0003_0000, 1'b0, 32'h0000_0000},
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd4, 32'hFFFF_8000, 1'b0, 32'h0000_0000},
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd6, 32'h0000_0001, 1'b0, 32'h0000_0000},
		'{ROW_SAMPLE, REG_PROP_GAIN,     3'd2, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Next drive of one loop; advances that loop's history
	function automatic logic signed [DATA_W-1:0] pid_advance(
		input logic [CH_W-1:0]          ch,
		input logic signed [DATA_W-1:0] err
	);
		logic signed [95:0]       e0, e1, e2, acc, y_w;
		logic signed [DATA_W-1:0] y_new;
		if (int'(ch) >= CHANNELS) return '0;
		e0  = err;
		e1  = loop_err1[ch];
		e2  = loop_err2[ch];
		y_w = loop_drive[ch];
		acc = kp_now * (e0 - e1) + kd_now * (e0 - e1 - e1 + e2);
		// drop the integral term while the old drive sits on or past a limit
		if (loop_drive[ch] > lim_lo && loop_drive[ch] < lim_hi) begin
			acc = acc + ki_now * e0;
		end
		y_w = y_w + (acc >>> FRAC_W);
		if (y_w < lim_lo) begin
			y_new = lim_lo;
		end else if (y_w > lim_hi) begin
			y_new = lim_hi;
		end else begin
			y_new = y_w[DATA_W-1:0];
		end
		loop_err2[ch]  = loop_err1[ch];
		loop_err1[ch]  = err;
		loop_drive[ch] = y_new;
		return y_new;
	endfunction

	// Random value within +/- 2^span
	function automatic logic signed [DATA_W-1:0] rand_q16(input int span);
		logic signed [DATA_W-1:0] r;
		r = $urandom();
		return r >>> (31 - span);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_error();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4) return rand_q16(18);
		if (pick < 6) return rand_q16(24);
		if (pick < 9) return rand_q16(31);
		case ($urandom_range(0, 3))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	// Favor runs on one loop so back-to-back history updates get exercised
	function automatic logic [CH_W-1:0] pick_channel();
		if ($urandom_range(0, 1) == 1) return last_ch;
		return CH_W'($urandom_range(0, 2**CH_W - 1));
	endfunction

	task automatic report_mismatch(
		input string             what,
		input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] want
	);
		$display("%0t ns mismatch on %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	// Drop valids, then wait for the pipeline to empty
	task automatic settle();
		smp_bus.valid <= 1'b0;
		cfg_bus.valid <= 1'b0;
		while (pending_drives.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_PROP_GAIN:     kp_now = val;
			REG_INTEG_GAIN_DT: ki_now = val;
			REG_DERIV_GAIN_DT: kd_now = val;
			REG_OUT_MIN:       lim_lo = val;
			REG_OUT_MAX:       lim_hi = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic send_sample(
		input logic [CH_W-1:0]   ch,
		input logic [DATA_W-1:0] err,
		input logic              typed,
		input logic [DATA_W-1:0] want
	);
		logic signed [DATA_W-1:0] predicted;
		cfg_bus.valid <= 1'b0;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			smp_bus.valid <= 1'b0;
			@(negedge clk);
		end
		smp_bus.valid        <= 1'b1;
		smp_bus.channel      <= ch;
		smp_bus.error_sample <= err;
		do @(posedge clk); while (!smp_bus.ready);
		predicted = pid_advance(ch, err);
		pending_drives.push_back('{ch, typed ? want : predicted});
		last_ch = ch;
		@(negedge clk);
	endtask

	initial begin
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		drive_beat_t head;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_drives.size() == 0) begin
				report_mismatch("drive beat with nothing pending", res_bus.drive, '0);
			end else begin
				head = pending_drives.pop_front();
				if (res_bus.out_channel !== head.ch) begin
					report_mismatch("out_channel", DATA_W'(res_bus.out_channel), DATA_W'(head.ch));
				end
				if (res_bus.drive !== head.drive) begin
					report_mismatch("drive", res_bus.drive, head.drive);
				end
			end
		end
	end

	initial begin
		stall_cycles = 0;
		do begin
			@(posedge clk);
			if ((smp_bus.valid && smp_bus.ready) || (res_bus.valid && res_bus.ready) ||
			    (cfg_bus.valid && cfg_bus.ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end while (stall_cycles < STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int                       row;
		int                       seg;
		logic signed [DATA_W-1:0] g_p, g_i, g_d, lo, hi, swap;

		arst_n               = 1'b0;
		smp_bus.valid        = 1'b0;
		smp_bus.channel      = '0;
		smp_bus.error_sample = '0;
		cfg_bus.valid        = 1'b0;
		cfg_bus.index        = REG_PROP_GAIN;
		cfg_bus.data         = '0;
		kp_now               = '0;
		ki_now               = '0;
		kd_now               = '0;
		lim_lo               = OUT_MIN_RST;
		lim_hi               = OUT_MAX_RST;
		for (int i = 0; i < CHANNELS; i++) begin
			loop_drive[i] = '0;
			loop_err1[i]  = '0;
			loop_err2[i]  = '0;
		end
		mismatches   = 0;
		last_ch      = '0;
		src_idle_pct = 32;
		snk_idle_pct = 81;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (row = 0; row < PLAN_ROWS; row++) begin
			if (plan[row].kind == ROW_CFG) begin
				settle();
				cfg_write(plan[row].idx, plan[row].value);
			end else begin
				send_sample(plan[row].ch, plan[row].value, plan[row].typed, plan[row].want);
			end
		end

		for (seg = 0; seg < SEGMENTS; seg++) begin
			if (seg < 2) begin
				src_idle_pct = 32;
				snk_idle_pct = 81;
			end else if (seg < 4) begin
				src_idle_pct = 81;
				snk_idle_pct = 32;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			settle();
			case (seg)
				0: begin
					g_p = rand_q16(17); g_i = rand_q16(15); g_d = rand_q16(15);
					lo  = LIM_100_N;    hi  = LIM_100_P;
				end
				1: begin
					g_p = Q_MAX; g_i = Q_MIN; g_d = Q_MIN;
					lo  = Q_MIN; hi  = Q_MAX;
				end
				2: begin
					g_p = rand_q16(31); g_i = rand_q16(31); g_d = rand_q16(31);
					lo  = rand_q16(20); hi  = rand_q16(20);
					// invert the limits
					if (lo < hi) begin
						swap = lo; lo = hi; hi = swap;
					end
				end
				3: begin
					g_p = rand_q16(17); g_i = rand_q16(17); g_d = rand_q16(17);
					lo  = rand_q16(22); hi  = lo;
				end
				4: begin
					g_p = rand_q16(17); g_i = rand_q16(15); g_d = rand_q16(15);
					lo  = rand_q16(24); hi  = rand_q16(24);
					if (lo > hi) begin
						swap = lo; lo = hi; hi = swap;
					end
				end
				default: begin
					g_p = rand_q16(31); g_i = rand_q16(31); g_d = rand_q16(31);
					lo  = rand_q16(31); hi  = rand_q16(31);
				end
			endcase
			cfg_write(REG_PROP_GAIN, g_p);
			cfg_write(REG_INTEG_GAIN_DT, g_i);
			cfg_write(REG_DERIV_GAIN_DT, g_d);
			cfg_write(REG_OUT_MIN, lo);
			cfg_write(REG_OUT_MAX, hi);
			repeat (SEG_ITEMS) send_sample(pick_channel(), rand_error(), 1'b0, '0);
		end

		settle();
		repeat (PIPE_DEPTH) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/mvp_pkg.sv
hw/rtl/mvp_if.sv
hw/rtl/mvp_cfg_regs.sv
hw/rtl/mvp_err_hist.sv
hw/rtl/mvp_pipe.sv
hw/rtl/mvp_out_stage.sv
hw/rtl/multichannel_velocity_pid.sv
hw/rtl/mvp_checker.sv
tb/sv/tb_multichannel_velocity_pid.sv
